FILE: src/abf_pkg.sv
`timescale 1ns / 1ps
// abf_pkg: shared constants, command struct and reciprocal table for the
// alpha bleed filter. No dependencies.
package abf_pkg;

  localparam int DEF_MAX_WIDTH = 32;
  localparam int HEIGHT_LIMIT  = 4096;

  localparam int TW_BITS       = 6;
  localparam int TH_BITS       = 13;
  localparam int ROW_BITS      = 12;
  localparam int CH_BITS       = 8;
  localparam int PIX_BITS      = 32;
  localparam int SUM_BITS      = 12;   // 9 * 255 fits
  localparam int CNT_BITS      = 4;    // up to 9 taps
  localparam int MAX_TAPS      = 9;
  localparam int RECIP_SHIFT   = 18;
  localparam int RECIP_BITS    = 19;
  localparam int PROD_BITS     = SUM_BITS + RECIP_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [TW_BITS-1:0] TW_RESET = 6'd16;
  localparam logic [TH_BITS-1:0] TH_RESET = 13'd16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TILE_WIDTH  = 1'b0,
    CFG_TILE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  // controller -> datapath
  typedef struct packed {
    logic  rd_en;       // tap read issued this cycle
    logic  tap_use;     // tap lies inside the tile
    logic  tap_center;  // tap is the pixel being produced
    logic  clr_acc;     // start of a new window
    logic  mul_en;      // one channel through the divider
    chan_t mul_ch;
    logic  load;        // move result into the output register
    logic  last;        // final result of the tile
  } dp_cmd_t;

  // ceil(2^18 / d); exact floor division for sums up to 9 * 255
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] d);
    case (d)
      4'd1:    recip = 19'd262144;
      4'd2:    recip = 19'd131072;
      4'd3:    recip = 19'd87382;
      4'd4:    recip = 19'd65536;
      4'd5:    recip = 19'd52429;
      4'd6:    recip = 19'd43691;
      4'd7:    recip = 19'd37450;
      4'd8:    recip = 19'd32768;
      4'd9:    recip = 19'd29128;
      default: recip = '0;
    endcase
  endfunction

endpackage

FILE: src/alpha_bleed_3x3_filter_core.sv
`timescale 1ns / 1ps
// alpha_bleed_3x3_filter_core: top level of the 3x3 alpha bleed filter.
// Depends on abf_pkg, abf_ctrl, abf_datapath (and abf_ram below it).
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+------------------
//  in      | red green blue alpha                      | in  | in_valid/in_stall
//  out     | out_red out_green out_blue out_alpha      | out | out_valid/out_stall
//          | last_of_tile                              |     |
//  cfg     | cfg_index cfg_data                        | in  | cfg_valid/cfg_ready
//
// Sequence: a pixel beat whose arrival closes no window leaves the sequencer
//   idle. Each result it closes takes nine tap reads from the single-port
//   row store, one drain, three passes through the shared reciprocal
//   multiplier, one finish and one load; in_stall stays high until all k
//   results of the beat are loaded (k up to MAX_WIDTH+2 on the final pixel).
// Reset: synchronous, active high; sizes return to 16x16, counters to zero.
//   The row store is not cleared; every window only reads rows of its tile.
// Stalls: a result sits in the output register while the next one is
//   computed; out_stall only holds the sequencer at a load.
// Config: cfg_ready is high outside reset; index 0 is tile_width, 1 is
//   tile_height. Write only between tiles or once all results are out.
module alpha_bleed_3x3_filter_core #(
  parameter int MAX_WIDTH = abf_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [abf_pkg::CH_BITS-1:0]       red,
  input  logic [abf_pkg::CH_BITS-1:0]       green,
  input  logic [abf_pkg::CH_BITS-1:0]       blue,
  input  logic [abf_pkg::CH_BITS-1:0]       alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [abf_pkg::CH_BITS-1:0]       out_red,
  output logic [abf_pkg::CH_BITS-1:0]       out_green,
  output logic [abf_pkg::CH_BITS-1:0]       out_blue,
  output logic [abf_pkg::CH_BITS-1:0]       out_alpha,
  output logic                              last_of_tile,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [abf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [abf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW = $clog2(3*MAX_WIDTH);

  // controller <-> datapath
  abf_pkg::dp_cmd_t cmd;
  logic             out_free;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // sequencer: tile position, row slots, tap walk, divide and load steps
  abf_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // three-row store, accumulators, divider, output register
  abf_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .last_of_tile (last_of_tile)
  );

endmodule

FILE: src/abf_ram.sv
`timescale 1ns / 1ps
// abf_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module abf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/abf_ctrl.sv
`timescale 1ns / 1ps
// abf_ctrl: tile counters, config registers and the per-result sequencer
// (tap reads, divide, load). Depends on abf_pkg.
module abf_ctrl #(
  parameter int MAX_WIDTH = abf_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [abf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [abf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                out_free,
  output abf_pkg::dp_cmd_t                    cmd,
  output logic                                wr_en,
  output logic [$clog2(3*MAX_WIDTH)-1:0]      wr_addr,
  output logic [$clog2(3*MAX_WIDTH)-1:0]      rd_addr
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(3*MAX_WIDTH);
  localparam int RW = abf_pkg::ROW_BITS;
  localparam int WB = abf_pkg::TW_BITS;
  localparam int HB = abf_pkg::TH_BITS;

  localparam logic [1:0] TAP_LO  = 2'd0;
  localparam logic [1:0] TAP_MID = 2'd1;
  localparam logic [1:0] TAP_HI  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TAP, ST_DRAIN, ST_MUL, ST_FIN, ST_LOAD
  } state_t;

  state_t              st;
  logic [WB-1:0]       tile_width;
  logic [HB-1:0]       tile_height;
  logic [CW-1:0]       col_cnt;
  logic [RW-1:0]       row_cnt;
  logic [1:0]          row_slot;
  logic [CW-1:0]       job_x;
  logic [CW-1:0]       job_end;
  logic [RW-1:0]       job_y;
  logic [1:0]          job_slot;
  logic                flush_pend;
  logic                in_flush;
  logic [1:0]          tap_dy;
  logic [1:0]          tap_dx;
  abf_pkg::chan_t      mul_ch;

  logic [WB-1:0]       w_eff;
  logic [HB-1:0]       h_eff;
  logic                accept;
  logic                restart;
  logic [CW-1:0]       c;
  logic [RW-1:0]       r;
  logic [1:0]          s;
  logic                c_last;
  logic                r_last;
  logic                has_a;
  logic [CW-1:0]       col_next;
  logic [RW-1:0]       row_next;
  logic [1:0]          slot_next;
  logic                ny_ok;
  logic                nx_ok;
  logic [1:0]          ny_slot;
  logic [CW-1:0]       nx;

  function automatic logic [1:0] slot_inc(input logic [1:0] v);
    slot_inc = (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] v);
    slot_dec = (v == 2'd0) ? 2'd2 : v - 2'd1;
  endfunction

  function automatic logic [AW-1:0] slot_base(input logic [1:0] v);
    case (v)
      2'd1:    slot_base = AW'(MAX_WIDTH);
      2'd2:    slot_base = AW'(2*MAX_WIDTH);
      default: slot_base = '0;
    endcase
  endfunction

  // out-of-range sizes clamp
  always_comb begin
    if (tile_width == '0) begin
      w_eff = WB'(1);
    end else if (7'(tile_width) > 7'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = tile_width;
    end
    if (tile_height == '0) begin
      h_eff = HB'(1);
    end else if (tile_height > HB'(abf_pkg::HEIGHT_LIMIT)) begin
      h_eff = HB'(abf_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = tile_height;
    end
  end

  assign in_stall  = rst || (st != ST_IDLE);
  assign cfg_ready = !rst;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = accept;

  // position of the arriving pixel
  always_comb begin
    restart = (7'(col_cnt) >= 7'(w_eff)) || (HB'(row_cnt) >= h_eff);
    c       = restart ? '0 : col_cnt;
    r       = restart ? '0 : row_cnt;
    s       = restart ? 2'd0 : row_slot;
    c_last  = (7'(c) == 7'(w_eff) - 7'd1);
    r_last  = (HB'(r) == h_eff - HB'(1));
    has_a   = (r != '0) && ((c != '0) || c_last);
    wr_addr = slot_base(s) + AW'(c);
    if (c_last && r_last) begin
      col_next  = '0;
      row_next  = '0;
      slot_next = 2'd0;
    end else if (c_last) begin
      col_next  = '0;
      row_next  = r + RW'(1);
      slot_next = slot_inc(s);
    end else begin
      col_next  = c + CW'(1);
      row_next  = r;
      slot_next = s;
    end
  end

  // tap address and in-tile test
  always_comb begin
    case (tap_dy)
      TAP_LO: begin
        ny_ok   = (job_y != '0);
        ny_slot = slot_dec(job_slot);
      end
      TAP_MID: begin
        ny_ok   = 1'b1;
        ny_slot = job_slot;
      end
      default: begin
        ny_ok   = (HB'(job_y) + HB'(1) < h_eff);
        ny_slot = slot_inc(job_slot);
      end
    endcase
    case (tap_dx)
      TAP_LO: begin
        nx_ok = (job_x != '0);
        nx    = job_x - CW'(1);
      end
      TAP_MID: begin
        nx_ok = 1'b1;
        nx    = job_x;
      end
      default: begin
        nx_ok = (7'(job_x) + 7'd1 < 7'(w_eff));
        nx    = nx_ok ? job_x + CW'(1) : job_x;
      end
    endcase
    rd_addr = slot_base(ny_slot) + AW'(nx);
  end

  always_comb begin
    cmd = '0;
    case (st)
      ST_TAP: begin
        cmd.rd_en      = 1'b1;
        cmd.tap_use    = ny_ok && nx_ok;
        cmd.tap_center = (tap_dy == TAP_MID) && (tap_dx == TAP_MID);
        cmd.clr_acc    = (tap_dy == TAP_LO) && (tap_dx == TAP_LO);
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ch = mul_ch;
      end
      ST_LOAD: begin
        cmd.load = out_free;
        cmd.last = in_flush && (job_x == job_end);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      tile_width  <= abf_pkg::TW_RESET;
      tile_height <= abf_pkg::TH_RESET;
      col_cnt     <= '0;
      row_cnt     <= '0;
      row_slot    <= 2'd0;
      job_x       <= '0;
      job_end     <= '0;
      job_y       <= '0;
      job_slot    <= 2'd0;
      flush_pend  <= 1'b0;
      in_flush    <= 1'b0;
      tap_dy      <= TAP_LO;
      tap_dx      <= TAP_LO;
      mul_ch      <= abf_pkg::CH_RED;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          abf_pkg::CFG_TILE_WIDTH:  tile_width  <= cfg_data[WB-1:0];
          abf_pkg::CFG_TILE_HEIGHT: tile_height <= cfg_data;
          default: ;
        endcase
      end
      case (st)
        ST_IDLE: begin
          if (accept) begin
            col_cnt  <= col_next;
            row_cnt  <= row_next;
            row_slot <= slot_next;
            tap_dy   <= TAP_LO;
            tap_dx   <= TAP_LO;
            if (has_a) begin
              // previous row: one or two pixels whose windows just closed
              job_x      <= (c != '0) ? c - CW'(1) : c;
              job_end    <= c_last ? c : c - CW'(1);
              job_y      <= r - RW'(1);
              job_slot   <= slot_dec(s);
              flush_pend <= c_last && r_last;
              in_flush   <= 1'b0;
              st         <= ST_TAP;
            end else if (c_last && r_last) begin
              job_x      <= '0;
              job_end    <= CW'(w_eff - WB'(1));
              job_y      <= r;
              job_slot   <= s;
              flush_pend <= 1'b0;
              in_flush   <= 1'b1;
              st         <= ST_TAP;
            end
          end
        end
        ST_TAP: begin
          if (tap_dx == TAP_HI) begin
            tap_dx <= TAP_LO;
            if (tap_dy == TAP_HI) begin
              st <= ST_DRAIN;
            end else begin
              tap_dy <= tap_dy + 2'd1;
            end
          end else begin
            tap_dx <= tap_dx + 2'd1;
          end
        end
        ST_DRAIN: begin
          mul_ch <= abf_pkg::CH_RED;
          st     <= ST_MUL;
        end
        ST_MUL: begin
          case (mul_ch)
            abf_pkg::CH_RED:   mul_ch <= abf_pkg::CH_GREEN;
            abf_pkg::CH_GREEN: mul_ch <= abf_pkg::CH_BLUE;
            default:           st     <= ST_FIN;
          endcase
        end
        ST_FIN: begin
          st <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            tap_dy <= TAP_LO;
            tap_dx <= TAP_LO;
            if (job_x == job_end) begin
              if (flush_pend) begin
                // move on to the final row
                job_x      <= '0;
                job_end    <= CW'(w_eff - WB'(1));
                job_y      <= job_y + RW'(1);
                job_slot   <= slot_inc(job_slot);
                flush_pend <= 1'b0;
                in_flush   <= 1'b1;
                st         <= ST_TAP;
              end else begin
                in_flush <= 1'b0;
                st       <= ST_IDLE;
              end
            end else begin
              job_x <= job_x + CW'(1);
              st    <= ST_TAP;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_job_order: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> (job_x <= job_end))
    else $error("job column ran past its end");

  a_counters_in_tile: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((7'(col_cnt) < $past(7'(w_eff))) && (HB'(row_cnt) < $past(h_eff))))
    else $error("tile counters left the tile");

  a_last_after_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.last |-> ((col_cnt == '0) && (row_cnt == '0)))
    else $error("last result while counters not wrapped");

endmodule

FILE: src/abf_datapath.sv
`timescale 1ns / 1ps
// abf_datapath: three-row pixel store, window accumulators, reciprocal
// divider and output register. Depends on abf_pkg and abf_ram.
module abf_datapath #(
  parameter int MAX_WIDTH = abf_pkg::DEF_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  abf_pkg::dp_cmd_t                  cmd,
  input  logic                              wr_en,
  input  logic [$clog2(3*MAX_WIDTH)-1:0]    wr_addr,
  input  logic [$clog2(3*MAX_WIDTH)-1:0]    rd_addr,
  input  logic [abf_pkg::CH_BITS-1:0]       red,
  input  logic [abf_pkg::CH_BITS-1:0]       green,
  input  logic [abf_pkg::CH_BITS-1:0]       blue,
  input  logic [abf_pkg::CH_BITS-1:0]       alpha,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [abf_pkg::CH_BITS-1:0]       out_red,
  output logic [abf_pkg::CH_BITS-1:0]       out_green,
  output logic [abf_pkg::CH_BITS-1:0]       out_blue,
  output logic [abf_pkg::CH_BITS-1:0]       out_alpha,
  output logic                              last_of_tile
);

  localparam int CB = abf_pkg::CH_BITS;
  localparam int SB = abf_pkg::SUM_BITS;
  localparam int NB = abf_pkg::CNT_BITS;
  localparam int PB = abf_pkg::PROD_BITS;
  localparam int RS = abf_pkg::RECIP_SHIFT;

  logic [abf_pkg::PIX_BITS-1:0] rd_data;
  logic                         tap_vld_d;
  logic                         tap_use_d;
  logic                         tap_center_d;
  logic [SB-1:0]                sum_r;
  logic [SB-1:0]                sum_g;
  logic [SB-1:0]                sum_b;
  logic [NB-1:0]                acc_cnt;
  logic [abf_pkg::PIX_BITS-1:0] center;
  logic [SB-1:0]                sel_sum;
  logic [PB-1:0]                prod;
  logic                         mul_vld_d;
  abf_pkg::chan_t               ch_d;
  logic [CB-1:0]                q_r;
  logic [CB-1:0]                q_g;
  logic [CB-1:0]                q_b;
  logic                         hit;
  logic                         bleed;

  abf_ram #(
    .WIDTH(abf_pkg::PIX_BITS),
    .DEPTH(3*MAX_WIDTH)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({alpha, blue, green, red}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign hit      = tap_vld_d && tap_use_d && (rd_data[31:24] != '0);
  assign bleed    = (center[31:24] == '0) && (acc_cnt != '0);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (cmd.mul_ch)
      abf_pkg::CH_GREEN: sel_sum = sum_g;
      abf_pkg::CH_BLUE:  sel_sum = sum_b;
      default:           sel_sum = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_vld_d <= 1'b0;
      mul_vld_d <= 1'b0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      tap_vld_d <= cmd.rd_en;
      mul_vld_d <= cmd.mul_en;
      if (cmd.clr_acc) begin
        acc_cnt <= '0;
      end else if (hit) begin
        acc_cnt <= acc_cnt + NB'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tap_use_d    <= cmd.tap_use;
    tap_center_d <= cmd.tap_center;
    if (cmd.clr_acc) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (hit) begin
      sum_r <= sum_r + SB'(rd_data[7:0]);
      sum_g <= sum_g + SB'(rd_data[15:8]);
      sum_b <= sum_b + SB'(rd_data[23:16]);
    end
    if (tap_vld_d && tap_center_d) begin
      center <= rd_data;
    end
    // floor(sum / cnt) as a multiply by the rounded-up reciprocal
    if (cmd.mul_en) begin
      prod <= PB'(sel_sum) * PB'(abf_pkg::recip(acc_cnt));
      ch_d <= cmd.mul_ch;
    end
    if (mul_vld_d) begin
      case (ch_d)
        abf_pkg::CH_GREEN: q_g <= prod[RS+CB-1:RS];
        abf_pkg::CH_BLUE:  q_b <= prod[RS+CB-1:RS];
        default:           q_r <= prod[RS+CB-1:RS];
      endcase
    end
    if (cmd.load) begin
      out_red      <= bleed ? q_r : center[7:0];
      out_green    <= bleed ? q_g : center[15:8];
      out_blue     <= bleed ? q_b : center[23:16];
      out_alpha    <= center[31:24];
      last_of_tile <= cmd.last;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    acc_cnt <= NB'(abf_pkg::MAX_TAPS))
    else $error("window count beyond nine taps");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending beat");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("loaded result not presented");

endmodule
